/* rtl/oets_pkg.sv */
// shared constants and types of the odd-even transposition sorter
// no dependencies; imported by oets_row, oets_ctrl and the top level
package oets_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int VALUE_W      = 32;
   localparam int DIGIT_W      = 8;
   localparam int NUM_DIGITS   = VALUE_W / DIGIT_W;
   localparam int DIGIT_CNT_W  = $clog2(NUM_DIGITS);
   localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);

   // values are held in offset binary so that digits compare unsigned
   localparam logic [VALUE_W-1:0] SIGN_FLIP = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SORT = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic emit;
      logic rotate;
      logic first_digit;
      logic last_digit;
      logic odd_phase;
   } row_cmd_type;

endpackage

/* rtl/oets_row.sv */
// row of sorter cells: each holds one value in a rotating digit shift register
// neighbor pairs compare one digit per cycle, most significant first; uses oets_pkg
module oets_row (
   input  logic                         clock,
   input  logic                         reset,
   input  oets_pkg::row_cmd_type        cmd,
   input  logic [oets_pkg::VALUE_W-1:0] load_value,
   output logic [oets_pkg::VALUE_W-1:0] head_value,
   output logic                         head_more
);
   import oets_pkg::*;

   logic [VALUE_W-1:0]      cell_ff [MAX_ELEMENTS];
   logic [VALUE_W-1:0]      cell_in [MAX_ELEMENTS];
   logic [VALUE_W-1:0]      rot     [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] occ_ff;
   logic [MAX_ELEMENTS-1:0] occ_in;
   logic [MAX_ELEMENTS-2:0] gt_ff;
   logic [MAX_ELEMENTS-2:0] gt_in;
   logic [MAX_ELEMENTS-2:0] eq_ff;
   logic [MAX_ELEMENTS-2:0] eq_in;
   logic [MAX_ELEMENTS-1:0] swap;

   // compare state per pair, indexed by the left cell
   for (genvar j = 0; j < MAX_ELEMENTS - 1; j++) begin : g_pair
      localparam logic PARITY = 1'(j % 2);
      logic [DIGIT_W-1:0] digit_a;
      logic [DIGIT_W-1:0] digit_b;
      logic               base_eq;
      logic               base_gt;

      assign digit_a  = cell_ff[j][VALUE_W-1 -: DIGIT_W];
      assign digit_b  = cell_ff[j+1][VALUE_W-1 -: DIGIT_W];
      assign base_eq  = cmd.first_digit | eq_ff[j];
      assign base_gt  = ~cmd.first_digit & gt_ff[j];
      assign gt_in[j] = base_gt | (base_eq & (digit_a > digit_b));
      assign eq_in[j] = base_eq & (digit_a == digit_b);
      // swap only pairs of this phase whose right cell is loaded
      assign swap[j]  = cmd.last_digit & (PARITY == cmd.odd_phase) & occ_ff[j+1] & gt_in[j];
   end
   assign swap[MAX_ELEMENTS-1] = 1'b0;

   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      logic [VALUE_W-1:0] below_val;
      logic [VALUE_W-1:0] below_rot;
      logic [VALUE_W-1:0] above_val;
      logic [VALUE_W-1:0] above_rot;
      logic               below_occ;
      logic               above_occ;
      logic               swap_below;

      assign rot[i] = {cell_ff[i][VALUE_W-DIGIT_W-1:0], cell_ff[i][VALUE_W-1 -: DIGIT_W]};

      if (i == 0) begin : g_bottom
         assign below_val  = load_value ^ SIGN_FLIP;
         assign below_rot  = '0;
         assign below_occ  = 1'b1;
         assign swap_below = 1'b0;
      end else begin : g_inner_lo
         assign below_val  = cell_ff[i-1];
         assign below_rot  = rot[i-1];
         assign below_occ  = occ_ff[i-1];
         assign swap_below = swap[i-1];
      end

      if (i == MAX_ELEMENTS - 1) begin : g_top
         assign above_val = '0;
         assign above_rot = '0;
         assign above_occ = 1'b0;
      end else begin : g_inner_hi
         assign above_val = cell_ff[i+1];
         assign above_rot = rot[i+1];
         assign above_occ = occ_ff[i+1];
      end

      assign cell_in[i] = cmd.load   ? below_val :
                          cmd.emit   ? above_val :
                          cmd.rotate ? (swap[i]    ? above_rot :
                                        swap_below ? below_rot : rot[i]) :
                          cell_ff[i];
      assign occ_in[i]  = cmd.load ? below_occ :
                          cmd.emit ? above_occ : occ_ff[i];
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (cmd.rotate) begin
         gt_ff <= gt_in;
         eq_ff <= eq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign head_value = cell_ff[0] ^ SIGN_FLIP;
   assign head_more  = occ_ff[1];

endmodule

/* rtl/oets_ctrl.sv */
// sequencer of the sorter: load, digit-serial sort phases, emit
// drives the cell row through a command struct; uses oets_pkg
module oets_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_last,
   output oets_pkg::row_cmd_type cmd
);
   import oets_pkg::*;

   state_type              state_ff;
   state_type              state_in;
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_in;
   logic [COUNT_W-1:0]     phase_ff;
   logic [COUNT_W-1:0]     phase_in;
   logic [DIGIT_CNT_W-1:0] digit_ff;
   logic [DIGIT_CNT_W-1:0] digit_in;
   logic                   req_beat;
   logic                   rsp_beat;
   logic                   last_digit;

   assign req_ready  = (state_ff == ST_LOAD);
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign req_beat   = req_valid & req_ready;
   assign rsp_beat   = rsp_valid & rsp_ready;
   assign last_digit = (digit_ff == DIGIT_CNT_W'(NUM_DIGITS - 1));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      digit_in = digit_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_beat) begin
               count_in = count_ff + COUNT_W'(1);
               if (req_last || count_ff == COUNT_W'(MAX_ELEMENTS - 1)) begin
                  state_in = ST_SORT;
                  phase_in = '0;
                  digit_in = '0;
               end
            end
         end
         ST_SORT: begin
            digit_in = digit_ff + DIGIT_CNT_W'(1);
            if (last_digit) begin
               // one phase per loaded element
               if (phase_ff == count_ff - COUNT_W'(1)) begin
                  state_in = ST_EMIT;
               end else begin
                  phase_in = phase_ff + COUNT_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (rsp_beat && rsp_last) begin
               state_in = ST_LOAD;
               count_in = '0;
            end
         end
         default: begin
            state_in = ST_LOAD;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         phase_ff <= '0;
         digit_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         digit_ff <= digit_in;
      end
   end

   always_comb begin
      cmd             = '0;
      cmd.load        = req_beat;
      cmd.emit        = rsp_beat;
      cmd.rotate      = (state_ff == ST_SORT);
      cmd.first_digit = (digit_ff == '0);
      cmd.last_digit  = last_digit;
      cmd.odd_phase   = phase_ff[0];
   end

endmodule

/* rtl/odd_even_transposition_sorter.sv */
// Odd-even transposition sorter. Up to 64 signed 32-bit values are taken one per beat;
// the beat with tlast set, or the 64th beat, ends the set. The set is then sorted in place
// by n phases of odd-even transposition over a row of cells, where each phase compares and
// swaps the active neighbor pairs of its parity at once, one 8-bit digit per cycle from the
// top. The n values then leave in ascending order, one per beat, the largest with tlast set;
// input is not taken during sort or emit.
// Top level; uses oets_pkg, oets_ctrl and oets_row.
module odd_even_transposition_sorter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value_res[31:0]
   output logic        rsp_tlast
);
   import oets_pkg::*;

   row_cmd_type        cmd;
   logic [VALUE_W-1:0] head_value;
   logic               head_more;

   oets_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_last  (~head_more),
      .cmd       (cmd)
   );

   oets_row u_row (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .load_value (req_tdata),
      .head_value (head_value),
      .head_more  (head_more)
   );

   assign rsp_tdata = head_value;
   assign rsp_tlast = ~head_more;

endmodule

/* rtl/oets_checker.sv */
// port-level checks for the odd-even transposition sorter
// bound to the top level below; no other dependencies
module oets_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // load and emit never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while results pending");

   // a closing input beat is followed by neither input ready nor a result shown
   a_last_in_stops: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready && !rsp_tvalid)
      else $error("input taken or result shown right after last input beat");

   // results continue until the flagged one
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("result run ended without last flag");

   // after the flagged result the block goes back to loading
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("block did not return to load after last result");

endmodule

bind odd_even_transposition_sorter oets_checker u_oets_checker (.*);
